// ===== rtl/jsm_pkg.sv =====
// ============================================================================
// jsm_pkg
// Shared types, character codes and keyword helpers for the JSON secret
// value masker.
// ============================================================================
package jsm_pkg;

	localparam int BYTE_W  = 8;
	localparam int CAP_W   = 16;
	localparam int WIN_LEN = 13;
	localparam int QDEPTH  = 4;
	localparam int MASK_LEN = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 16'd4096;

	localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
	localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
	localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
	localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
	localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
	localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;

	// Keywords, first character in the most significant byte.
	localparam logic [39:0]  KW_TOKEN  = "token";
	localparam logic [55:0]  KW_APIKEY = "api_key";
	localparam logic [103:0] KW_AUTHZ  = "authorization";
	localparam logic [63:0]  KW_PASSWD = "password";
	localparam logic [47:0]  KW_SECRET = "secret";
	localparam logic [31:0]  KW_AUTH   = "auth";
	localparam logic [47:0]  KW_BEARER = "bearer";
	localparam logic [23:0]  KW_KEY    = "key";

	// One output command: an optional slice of the quoted mask text,
	// followed by an optional single byte.
	typedef struct packed {
		logic              pre_start;  // 0: start at the opening quote, 1: at the stars
		logic [2:0]        pre_count;  // mask bytes to emit
		logic              has_byte;   // trailing byte present
		logic [BYTE_W-1:0] data;       // trailing byte
		logic              last;       // trailing byte is the terminator
	} jsm_cmd_t;

	// Mask text is quote, three stars, quote.
	function automatic logic [BYTE_W-1:0] mask_char(logic [2:0] idx);
		logic edge_pos;
		edge_pos = (idx == 3'd0) || (idx == 3'd4);
		return edge_pos ? CH_QUOTE : CH_STAR;
	endfunction

	function automatic logic [BYTE_W-1:0] to_lower(logic [BYTE_W-1:0] b);
		logic upper;
		upper = (b >= 8'h41) && (b <= 8'h5A);
		return upper ? (b | 8'h20) : b;
	endfunction

	// The newest byte of the window sits in the lowest byte lane.
	function automatic logic kw_hit(logic [WIN_LEN*BYTE_W-1:0] w);
		logic hit;
		hit = (w[39:0] == KW_TOKEN) || (w[55:0] == KW_APIKEY) ||
		      (w[103:0] == KW_AUTHZ) || (w[63:0] == KW_PASSWD) ||
		      (w[47:0] == KW_SECRET) || (w[31:0] == KW_AUTH) ||
		      (w[47:0] == KW_BEARER) || (w[23:0] == KW_KEY);
		return hit;
	endfunction

endpackage

// ===== rtl/jsm_front.sv =====
// ============================================================================
// jsm_front
// Classifies each input beat, tracks the key window and output space, and
// produces one output command per beat that yields any bytes.
// ============================================================================
module jsm_front #(
	parameter int KEY_LIMIT = 63
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wen,
	input  logic [jsm_pkg::CAP_W-1:0]    cfg_wdata,
	input  logic                         accept,
	input  logic [jsm_pkg::BYTE_W-1:0]   in_byte,
	input  logic                         in_end,
	output logic                         push,
	output jsm_pkg::jsm_cmd_t            cmd
);

	localparam int KLW = $clog2(KEY_LIMIT + 1);
	localparam int WW  = jsm_pkg::WIN_LEN * jsm_pkg::BYTE_W;

	localparam logic [2:0] M_COPY    = 3'd0;
	localparam logic [2:0] M_KEY     = 3'd1;
	localparam logic [2:0] M_SEP     = 3'd2;
	localparam logic [2:0] M_SKIPSTR = 3'd3;
	localparam logic [2:0] M_SKIPVAL = 3'd4;

	logic [2:0]                   mode_q;
	logic [KLW-1:0]               klen_q;
	logic [WW-1:0]                win_q;
	logic                         matched_q;
	logic [jsm_pkg::CAP_W-1:0]    space_q;
	logic [jsm_pkg::CAP_W-1:0]    cap_q;

	logic                         is_quote, is_sep, is_term;
	logic [2:0]                   m1, m2, mode_d;
	logic [WW-1:0]                win_new;
	logic                         hit;
	logic [2:0]                   mask_n;
	logic                         pre_start;
	logic [2:0]                   pre_count;
	logic                         want_byte, is_last, take, clear;
	logic [jsm_pkg::BYTE_W-1:0]   data;
	logic [jsm_pkg::CAP_W-1:0]    space_mid, space_next;
	logic                         has_byte;
	logic                         active;

	always_comb begin
		is_quote = in_byte == jsm_pkg::CH_QUOTE;
		is_sep   = (in_byte == jsm_pkg::CH_SPACE) || (in_byte == jsm_pkg::CH_COLON);
		is_term  = (in_byte == jsm_pkg::CH_COMMA) || (in_byte == jsm_pkg::CH_RBRACE) ||
		           (in_byte == jsm_pkg::CH_RBRACK);

		// An over-long key ends without its quote; the byte is then handled
		// by whatever mode follows, possibly falling through the separator.
		m1 = mode_q;
		if (mode_q == M_KEY && !is_quote && klen_q >= KLW'(KEY_LIMIT)) begin
			m1 = matched_q ? M_SEP : M_COPY;
		end
		m2 = (m1 == M_SEP && !is_sep && !is_quote) ? M_SKIPVAL : m1;

		win_new = {win_q[WW-jsm_pkg::BYTE_W-1:0], jsm_pkg::to_lower(in_byte)};
		hit     = jsm_pkg::kw_hit(win_new);
		mask_n  = (space_q < jsm_pkg::CAP_W'(jsm_pkg::MASK_LEN)) ?
		          space_q[2:0] : 3'(jsm_pkg::MASK_LEN);

		pre_start = 1'b0;
		pre_count = 3'd0;
		want_byte = 1'b0;
		is_last   = 1'b0;
		data      = in_byte;
		mode_d    = m2;
		take      = 1'b0;
		clear     = 1'b0;

		if (in_end) begin
			data      = jsm_pkg::CH_NUL;
			is_last   = 1'b1;
			want_byte = 1'b1;
			unique case (mode_q)
				M_KEY: begin
					if (matched_q) begin
						pre_count = mask_n;
					end
				end
				M_SEP, M_SKIPVAL: begin
					pre_count = mask_n;
				end
				M_SKIPSTR: begin
					if (space_q >= 16'd3) begin
						pre_start = 1'b1;
						pre_count = 3'd3;
					end
				end
				default: begin
				end
			endcase
		end else begin
			unique case (m2)
				M_KEY: begin
					want_byte = 1'b1;
					if (is_quote) begin
						mode_d = matched_q ? M_SEP : M_COPY;
					end else begin
						take = 1'b1;
					end
				end
				M_SEP: begin
					want_byte = 1'b1;
					if (is_quote) begin
						mode_d = M_SKIPSTR;
					end
				end
				M_SKIPSTR: begin
					if (is_quote) begin
						if (space_q >= 16'd3) begin
							pre_start = 1'b1;
							pre_count = 3'd3;
						end
						want_byte = 1'b1;
						mode_d    = M_COPY;
					end
				end
				M_SKIPVAL: begin
					if (is_term) begin
						pre_count = mask_n;
						want_byte = 1'b1;
						mode_d    = M_COPY;
					end
				end
				default: begin
					want_byte = 1'b1;
					if (is_quote) begin
						mode_d = M_KEY;
						clear  = 1'b1;
					end
				end
			endcase
		end

		space_mid  = space_q - jsm_pkg::CAP_W'(pre_count);
		has_byte   = want_byte && (in_end || space_mid != '0);
		space_next = space_mid - jsm_pkg::CAP_W'(has_byte);

		active = accept && (in_end || space_q != '0);
		push   = active && (pre_count != 3'd0 || has_byte);

		cmd.pre_start = pre_start;
		cmd.pre_count = pre_count;
		cmd.has_byte  = has_byte;
		cmd.data      = data;
		cmd.last      = is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q     <= jsm_pkg::CAP_RESET;
			space_q   <= jsm_pkg::CAP_RESET - 16'd1;
			mode_q    <= M_COPY;
			klen_q    <= '0;
			win_q     <= '0;
			matched_q <= 1'b0;
		end else if (cfg_wen) begin
			cap_q     <= cfg_wdata;
			space_q   <= (cfg_wdata == '0) ? '0 : cfg_wdata - 16'd1;
			mode_q    <= M_COPY;
			klen_q    <= '0;
			win_q     <= '0;
			matched_q <= 1'b0;
		end else if (active) begin
			if (in_end) begin
				space_q   <= (cap_q == '0) ? '0 : cap_q - 16'd1;
				mode_q    <= M_COPY;
				klen_q    <= '0;
				win_q     <= '0;
				matched_q <= 1'b0;
			end else begin
				space_q <= space_next;
				mode_q  <= mode_d;
				if (clear) begin
					klen_q    <= '0;
					win_q     <= '0;
					matched_q <= 1'b0;
				end else if (take) begin
					klen_q    <= klen_q + KLW'(1);
					win_q     <= win_new;
					matched_q <= matched_q | hit;
				end
			end
		end
	end

endmodule

// ===== rtl/jsm_queue.sv =====
// ============================================================================
// jsm_queue
// Small command FIFO between the classifier and the byte emitter.
// ============================================================================
module jsm_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  jsm_pkg::jsm_cmd_t push_cmd,
	input  logic              pop,
	output logic              full,
	output logic              head_valid,
	output jsm_pkg::jsm_cmd_t head_cmd
);

	localparam int PW = $clog2(jsm_pkg::QDEPTH);
	localparam int CW = $clog2(jsm_pkg::QDEPTH + 1);

	jsm_pkg::jsm_cmd_t mem_q [jsm_pkg::QDEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]     count_q;

	assign full       = count_q == CW'(jsm_pkg::QDEPTH);
	assign head_valid = count_q != '0;
	assign head_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== rtl/jsm_back.sv =====
// ============================================================================
// jsm_back
// Expands the command at the queue head into output beats, one per cycle
// unless the sink stalls, through a registered output stage.
// ============================================================================
module jsm_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        head_valid,
	input  jsm_pkg::jsm_cmd_t           head_cmd,
	output logic                        pop,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [jsm_pkg::BYTE_W-1:0]  m_tdata,
	output logic                        m_tlast
);

	logic [2:0]                 pos_q;
	logic                       m_tvalid_q;
	logic [jsm_pkg::BYTE_W-1:0] m_tdata_q;
	logic                       m_tlast_q;

	logic                       load;
	logic                       in_prefix;
	logic [2:0]                 total;
	logic                       done;
	logic [jsm_pkg::BYTE_W-1:0] beat_data;
	logic                       beat_last;

	always_comb begin
		load      = head_valid && (!m_tvalid_q || m_tready);
		in_prefix = pos_q < head_cmd.pre_count;
		total     = head_cmd.pre_count + 3'(head_cmd.has_byte);
		done      = (pos_q + 3'd1) == total;
		beat_data = in_prefix ?
		            jsm_pkg::mask_char(pos_q + 3'(head_cmd.pre_start)) : head_cmd.data;
		beat_last = !in_prefix && head_cmd.last;
		pop       = load && done;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata_q <= beat_data;
			m_tlast_q <= beat_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			pos_q      <= '0;
		end else begin
			if (load) begin
				m_tvalid_q <= 1'b1;
				pos_q      <= done ? 3'd0 : pos_q + 3'd1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

// ===== rtl/json_secret_value_masker.sv =====
// ============================================================================
// json_secret_value_masker
// Passes JSON text through byte by byte and masks the values of keys that
// look like secrets.
// ============================================================================
// Path: an input beat's command is written into the queue at the edge that
// accepts the beat, and its output beats leave through the output register.
// Throughput: one input beat per cycle; one masking beat expands into up to
// six output beats, so input stalls only while the four-entry queue is full.
// Reset: arst_n clears the block at once; capacity returns to 4096 bytes and
// the text restarts in copy mode with empty queue and output stage.
module json_secret_value_masker #(
	parameter int KEY_LIMIT = 63
) (
	input  logic        clk,
	input  logic        arst_n,

	// Configuration: out_capacity, output size in bytes including the
	// terminator.
	input  logic        cfg_wen,
	input  logic [15:0] cfg_wdata,

	// Input text stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // end_of_text

	// Sanitized output stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic        m_tlast    // last, set on the terminator beat
);

	logic              accept;
	logic              push;
	jsm_pkg::jsm_cmd_t cmd;
	logic              full;
	logic              head_valid;
	jsm_pkg::jsm_cmd_t head_cmd;
	logic              pop;

	// The front side only waits on queue room, never on the output side, so
	// the sink can stall without blocking input until the queue fills.
	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	// Front: mode tracking, keyword matching and space accounting. Every
	// decision about which bytes appear is made here, one beat per cycle unless the queue is full.
	jsm_front #(
		.KEY_LIMIT (KEY_LIMIT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.in_byte   (s_tdata),
		.in_end    (s_tlast),
		.push      (push),
		.cmd       (cmd)
	);

	// Commands wait here while the back side spells out mask bursts.
	jsm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (cmd),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// Back: turns each command into its mask bytes and trailing byte.
	jsm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

// ===== tb/json_secret_value_masker_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// json_secret_value_masker_tb
// Self-checking testbench: JSON-like text goes in beat by beat, a scoreboard
// predicts the sanitized output and compares every output beat, in order,
// under several capacities and handshake idling patterns.
// ============================================================================

typedef struct packed {
	logic [7:0] data;
	logic       last;
} text_beat_t;

typedef enum logic [2:0] {
	MD_COPY,
	MD_KEY,
	MD_SEP,
	MD_SKIPSTR,
	MD_SKIPVAL
} masker_mode_e;

class masker_scoreboard;
	string        kw[8];
	int           key_limit;
	logic [15:0]  capacity;
	masker_mode_e mode;
	int           key_len;
	logic [7:0]   win[jsm_pkg::WIN_LEN];
	bit           matched;
	logic [15:0]  space;
	text_beat_t   due_bytes[$];
	int           errors;

	function new(int limit);
		kw = '{"token", "api_key", "authorization", "password",
		       "secret", "auth", "bearer", "key"};
		key_limit = limit;
		capacity = jsm_pkg::CAP_RESET;
		errors = 0;
		restart();
	endfunction

	function void restart();
		mode = MD_COPY;
		key_len = 0;
		foreach (win[i]) win[i] = 8'h00;
		matched = 0;
		space = (capacity == 16'd0) ? 16'd0 : capacity - 16'd1;
	endfunction

	function void set_capacity(logic [15:0] v);
		capacity = v;
		restart();
	endfunction

	function void emit(logic [7:0] b);
		if (space == 16'd0) return;
		space--;
		due_bytes.push_back('{b, 1'b0});
	endfunction

	function void emit_mask();
		emit(jsm_pkg::CH_QUOTE);
		emit(jsm_pkg::CH_STAR);
		emit(jsm_pkg::CH_STAR);
		emit(jsm_pkg::CH_STAR);
		emit(jsm_pkg::CH_QUOTE);
	endfunction

	function void emit_stars();
		if (space >= 16'd3) begin
			emit(jsm_pkg::CH_STAR);
			emit(jsm_pkg::CH_STAR);
			emit(jsm_pkg::CH_STAR);
		end
	endfunction

	// Shift the lower-cased byte into the window and look for a keyword
	// ending at the newest byte.
	function void learn_key_byte(logic [7:0] b);
		logic [7:0] lc;
		int         l;
		bit         hit;
		lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
		for (int i = 0; i < jsm_pkg::WIN_LEN - 1; i++) win[i] = win[i + 1];
		win[jsm_pkg::WIN_LEN - 1] = lc;
		key_len++;
		for (int i = 0; i < 8; i++) begin
			l = kw[i].len();
			if (key_len >= l) begin
				hit = 1;
				for (int j = 0; j < l; j++)
					if (win[jsm_pkg::WIN_LEN - l + j] != kw[i][j]) hit = 0;
				if (hit) matched = 1;
			end
		end
	endfunction

	function void predict_beat(logic [7:0] b, logic eot);
		bit again;
		if (eot) begin
			case (mode)
				MD_KEY: if (matched) emit_mask();
				MD_SEP, MD_SKIPVAL: emit_mask();
				MD_SKIPSTR: emit_stars();
				default: ;
			endcase
			due_bytes.push_back('{jsm_pkg::CH_NUL, 1'b1});
			restart();
			return;
		end
		if (space == 16'd0) return;
		do begin
			again = 0;
			case (mode)
				MD_KEY: begin
					if (b == jsm_pkg::CH_QUOTE) begin
						emit(b);
						mode = matched ? MD_SEP : MD_COPY;
					end else if (key_len < key_limit) begin
						emit(b);
						learn_key_byte(b);
					end else begin
						// Key too long: this byte is treated as the first
						// one after the key.
						mode = matched ? MD_SEP : MD_COPY;
						again = 1;
					end
				end
				MD_SEP: begin
					if (b == jsm_pkg::CH_SPACE || b == jsm_pkg::CH_COLON) begin
						emit(b);
					end else if (b == jsm_pkg::CH_QUOTE) begin
						emit(b);
						mode = MD_SKIPSTR;
					end else begin
						mode = MD_SKIPVAL;
						again = 1;
					end
				end
				MD_SKIPSTR: begin
					if (b == jsm_pkg::CH_QUOTE) begin
						emit_stars();
						emit(b);
						mode = MD_COPY;
					end
				end
				MD_SKIPVAL: begin
					if (b == jsm_pkg::CH_COMMA || b == jsm_pkg::CH_RBRACE ||
					    b == jsm_pkg::CH_RBRACK) begin
						emit_mask();
						mode = MD_COPY;
						emit(b);
					end
				end
				default: begin
					emit(b);
					if (b == jsm_pkg::CH_QUOTE) begin
						mode = MD_KEY;
						key_len = 0;
						foreach (win[i]) win[i] = 8'h00;
						matched = 0;
					end
				end
			endcase
		end while (again);
	endfunction

	function void note_error();
		errors++;
	endfunction

	function void check_beat(logic [7:0] b, logic l);
		text_beat_t want;
		if (due_bytes.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected output beat: data %02h last %0b", b, l);
		end else begin
			want = due_bytes.pop_front();
			if (want.data !== b || want.last !== l) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected data %02h last %0b, got data %02h last %0b",
					         want.data, want.last, b, l);
			end
		end
	endfunction
endclass

module json_secret_value_masker_tb;

	localparam int KEY_LIMIT   = 63;
	// Settling wait; it covers the queue write, the output register and the queue.
	localparam int SETTLE      = 16;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_LIMIT = 50000;
	localparam int RUN_LIMIT   = 6000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wen = 1'b0;
	logic [15:0] cfg_wdata = 16'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	masker_scoreboard sb;
	text_beat_t       text_plan[$];

	// Idling percentages, set per phase by the stimulus process.
	int src_idle = 0;
	int sink_stall = 0;
	// Raised once by the stimulus process to ask for the long receiver hold.
	bit hold_req = 0;

	json_secret_value_masker #(
		.KEY_LIMIT(KEY_LIMIT)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Receiver. It normally stalls at random; on request it holds tready low
	// for a long stretch once, counting the cycles itself, so that the
	// command queue fills and the input side has to stall.
	initial begin : receiver
		int  hold_left;
		bit  hold_taken;
		hold_left = 0;
		hold_taken = 0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= sink_stall);
			end
		end
	end

	// Monitor. Signals are read at the edge, before the nonblocking updates
	// of this step land. Output beats are checked before the input beat of
	// the same edge is predicted, since that input cannot have caused them.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) sb.check_beat(m_tdata, m_tlast);
			if (s_tvalid && s_tready) sb.predict_beat(s_tdata, s_tlast);
		end
	end

	// One input beat: random idle cycles first, then hold tvalid until the
	// block takes the beat. tvalid stays high on return so that back-to-back
	// beats need no extra edge.
	task automatic send_beat(input text_beat_t bt);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= bt.data;
		s_tlast  <= bt.last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic play_plan(output int count);
		count = text_plan.size();
		foreach (text_plan[i]) send_beat(text_plan[i]);
		s_tvalid <= 1'b0;
		text_plan.delete();
	endtask

	// Let the monitor predict the last input beat, then wait for every
	// predicted beat, then wait out the settling time for input beats that
	// cause no output.
	task automatic drain_quiet();
		@(posedge clk);
		while (sb.due_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Only called while the block is idle; the scoreboard takes the new
	// capacity at the same edge as the block.
	task automatic write_capacity(input logic [15:0] v);
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		sb.set_capacity(v);
		cfg_wen   <= 1'b0;
	endtask

	function automatic void push_byte(input logic [7:0] b);
		text_plan.push_back('{b, 1'b0});
	endfunction

	// The data byte of the end beat is ignored by the block, so it is random.
	function automatic void push_end();
		text_plan.push_back('{8'($urandom_range(255)), 1'b1});
	endfunction

	function automatic void push_str(input string s);
		for (int i = 0; i < s.len(); i++) push_byte(s[i]);
	endfunction

	// Letters flip to upper case at random; matching must ignore case.
	function automatic void push_mixed(input string s);
		logic [7:0] c;
		for (int i = 0; i < s.len(); i++) begin
			c = s[i];
			if (c >= "a" && c <= "z" && $urandom_range(1) == 1) c = c - 8'd32;
			push_byte(c);
		end
	endfunction

	// One key, separator and value. Half the keys are secrets, some are near
	// misses, some run past the key limit with a keyword before or after
	// the limit, some hold arbitrary bytes. A few lack the closing quote.
	function automatic void push_member();
		string      plain[6];
		string      lits[3];
		string      vchars;
		int         kind;
		int         n;
		int         pos;
		logic [7:0] b;
		plain  = '{"name", "id", "tok", "passwd", "secre", "beare"};
		lits   = '{"true", "false", "null"};
		vchars = "ab9 :,}]{";
		kind = $urandom_range(9);
		push_byte(jsm_pkg::CH_QUOTE);
		if (kind <= 4) begin
			if ($urandom_range(1) == 1) push_str("x_");
			push_mixed(sb.kw[$urandom_range(7)]);
			if ($urandom_range(2) == 0) push_str("_id");
		end else if (kind <= 6) begin
			push_mixed(plain[$urandom_range(5)]);
		end else if (kind == 7) begin
			n = $urandom_range(56, 72);
			pos = $urandom_range(n);
			for (int i = 0; i < n; i++) begin
				if (i == pos) push_mixed(sb.kw[$urandom_range(7)]);
				push_byte(8'("a" + $urandom_range(25)));
			end
		end else if (kind == 8) begin
			repeat ($urandom_range(1, 5)) begin
				b = 8'($urandom_range(255));
				if (b == jsm_pkg::CH_QUOTE) b = 8'h23;
				push_byte(b);
			end
		end
		if ($urandom_range(19) != 0) push_byte(jsm_pkg::CH_QUOTE);
		repeat ($urandom_range(3))
			push_byte($urandom_range(1) ? jsm_pkg::CH_COLON : jsm_pkg::CH_SPACE);
		case ($urandom_range(5))
			0, 1: begin
				push_byte(jsm_pkg::CH_QUOTE);
				repeat ($urandom_range(6)) push_byte(vchars[$urandom_range(vchars.len() - 1)]);
				push_byte(jsm_pkg::CH_QUOTE);
			end
			2: repeat ($urandom_range(1, 4)) push_byte(8'("0" + $urandom_range(9)));
			3: push_str(lits[$urandom_range(2)]);
			4: push_str("[1,2]");
			default: push_str("{\"k\":2}");
		endcase
	endfunction

	// A text is mostly an object of one or two members, sometimes raw noise.
	// Some texts are cut short at a random point; an open text ends without
	// the end beat, so that the next register write lands in mid-text.
	function automatic void build_text(input bit closed);
		int members;
		int cut;
		text_plan.delete();
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(1, 10)) push_byte(8'($urandom_range(255)));
		end else begin
			if ($urandom_range(4) != 0) push_str("{");
			members = $urandom_range(1, 2);
			for (int m = 0; m < members; m++) begin
				push_member();
				if (m < members - 1) push_byte(jsm_pkg::CH_COMMA);
				else case ($urandom_range(2))
					0: push_byte(jsm_pkg::CH_RBRACE);
					1: push_byte(jsm_pkg::CH_RBRACK);
					default: push_byte(jsm_pkg::CH_COMMA);
				endcase
				if ($urandom_range(3) == 0) push_byte(jsm_pkg::CH_SPACE);
			end
		end
		if (!closed || $urandom_range(6) == 0) begin
			cut = $urandom_range(text_plan.size() - 1);
			while (text_plan.size() > cut + 1) void'(text_plan.pop_back());
		end
		if (closed) push_end();
	endfunction

	task automatic run_phase(input int s_idle, input int r_stall, input logic [15:0] cap,
	                         input int quota, input bit leave_open);
		int count;
		int got;
		drain_quiet();
		write_capacity(cap);
		src_idle = s_idle;
		sink_stall = r_stall;
		count = 0;
		while (count < quota) begin
			build_text(1'b1);
			play_plan(got);
			count += got;
		end
		if (leave_open) begin
			build_text(1'b0);
			play_plan(got);
		end
	endtask

	initial begin : stimulus
		int got;
		int waited;
		sb = new(KEY_LIMIT);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset capacity: an upper-case keyword with a
		// number value dropped up to the comma, then a key followed by a
		// space and a masked string with a zero byte inside that the end of
		// text cuts off.
		push_str("\"KEY\":1,");
		text_plan.push_back('{8'h00, 1'b1});
		push_str("\"auth\" \"");
		push_byte(8'h00);
		text_plan.push_back('{8'hFF, 1'b1});
		play_plan(got);

		// Capacity one: only the terminator fits, all bytes are dropped.
		drain_quiet();
		write_capacity(16'd1);
		push_byte(8'hFF);
		push_byte(8'h00);
		push_end();
		play_plan(got);

		// Capacity seven: a zero byte in a key, a matched key at the end of
		// text, and a mask that only partly fits.
		drain_quiet();
		write_capacity(16'd7);
		push_byte(jsm_pkg::CH_QUOTE);
		push_byte(jsm_pkg::CH_NUL);
		push_str("key");
		push_end();
		play_plan(got);

		// Random part, one phase per idling pattern.
		run_phase(0, 0, 16'd4096, 12, 1'b1);
		run_phase(86, 0, 16'($urandom_range(2, 40)), 12, 1'b1);
		run_phase(0, 86, 16'd65535, 12, 1'b0);
		run_phase(32, 32, 16'($urandom_range(1, 24)), 12, 1'b0);

		// Pressure: the receiver holds off while the sender keeps offering
		// masking beats back to back.
		drain_quiet();
		write_capacity(16'd4096);
		src_idle = 0;
		sink_stall = 0;
		hold_req = 1;
		push_str("{");
		repeat (3) push_str("\"key\":1,");
		push_str("}");
		push_end();
		play_plan(got);

		@(posedge clk);
		waited = 0;
		while (sb.due_bytes.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE) @(posedge clk);
		if (sb.due_bytes.size() != 0) begin
			$display("%0d expected output beats never arrived", sb.due_bytes.size());
			sb.note_error();
		end

		if (sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin : watchdog
		#(RUN_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

endmodule
